### design/pru_pkg.sv
// Shared types and constants for the pixel replicate upscaler.
package pru_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_SCALE = 16;

   localparam int PIX_W      = 24;
   localparam int SCALE_W    = 5;
   localparam int SRC_W      = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 1'b1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_REPLAY = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [1:0] pad_bytes;
      logic       row_end;
      logic       last;
      logic       error;
   } rsp_item_type;

   // Per-item job information handed from the control stage to the copy emitter.
   typedef struct packed {
      logic       error;
      logic       is_load;
      logic       at_end;
      logic [1:0] pad_bytes;
   } job_type;

endpackage

### design/pru_line_store.sv
// Line buffer memory: one write port and one read port with registered read data.
module pru_line_store import pru_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int COL_W     = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a waiting replay item keeps its pixel.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pru_control.sv
// Configuration registers, row and pass counters, line store access and the job stage.
module pru_control import pru_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE,
   parameter int COL_W     = 10,
   parameter int PASS_W    = 4,
   parameter int CNT_W     = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  mem_wr_en,
   output logic                  mem_rd_en,
   output logic [COL_W-1:0]      mem_addr,
   output logic [PIX_W-1:0]      mem_wr_data,
   output logic                  job_valid,
   input  logic                  job_take,
   output job_type               job,
   output logic [PIX_W-1:0]      job_pix,
   output logic [CNT_W-1:0]      job_scale
);

   localparam int WE_W = (SRC_W > $clog2(MAX_WIDTH + 1)) ? SRC_W : $clog2(MAX_WIDTH + 1);
   localparam int SE_W = (SCALE_W > CNT_W) ? SCALE_W : CNT_W;

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SRC_W-1:0]   width_ff, width_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               job_valid_ff, job_valid_in;
   job_type            job_ff, job_in;
   logic [PIX_W-1:0]   job_pix_ff, job_pix_in;
   logic [CNT_W-1:0]   job_scale_ff, job_scale_in;

   logic [WE_W-1:0]  w_raw, w_eff, col_next;
   logic [SE_W-1:0]  s_raw, s_eff;
   logic [CNT_W-1:0] s_cnt, pass_next;
   logic [COL_W-1:0] col_cur;
   logic             accept, mode_err, at_end;
   logic [3:0]       pad_prod;

   always_comb begin
      w_raw = WE_W'(width_ff);
      if (w_raw == '0) begin
         w_eff = WE_W'(1);
      end else if (w_raw > WE_W'(MAX_WIDTH)) begin
         w_eff = WE_W'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      s_raw = SE_W'(scale_ff);
      if (s_raw == '0) begin
         s_eff = SE_W'(1);
      end else if (s_raw > SE_W'(MAX_SCALE)) begin
         s_eff = SE_W'(MAX_SCALE);
      end else begin
         s_eff = s_raw;
      end
   end

   assign s_cnt = s_eff[CNT_W-1:0];

   // The pad count (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4.
   assign pad_prod = w_eff[1:0] * s_eff[1:0];

   assign col_cur   = (WE_W'(col_ff) >= w_eff) ? '0 : col_ff;
   assign col_next  = WE_W'(col_cur) + WE_W'(1);
   assign at_end    = (col_next == w_eff);
   assign pass_next = CNT_W'(pass_ff) + CNT_W'(1);

   assign mode_err  = req_item.mode != ((pass_ff != '0) ? MODE_REPLAY : MODE_LOAD);
   assign req_stall = job_valid_ff && !job_take;
   assign accept    = req_valid && !req_stall;

   assign mem_wr_en   = accept && !mode_err && (req_item.mode == MODE_LOAD);
   assign mem_rd_en   = accept && !mode_err && (req_item.mode == MODE_REPLAY);
   assign mem_addr    = col_cur;
   assign mem_wr_data = {req_item.red, req_item.green, req_item.blue};

   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      col_in   = col_ff;
      pass_in  = pass_ff;
      if (accept && !mode_err) begin
         if (at_end) begin
            col_in  = '0;
            pass_in = (pass_next >= s_cnt) ? '0 : pass_next[PASS_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE_FACTOR: scale_in = csr_data[SCALE_W-1:0];
            CSR_SOURCE_WIDTH: width_in = csr_data[SRC_W-1:0];
            default: ;
         endcase
         col_in  = '0;
         pass_in = '0;
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      job_pix_in   = job_pix_ff;
      job_scale_in = job_scale_ff;
      if (!job_valid_ff || job_take) begin
         job_valid_in = accept;
         if (accept) begin
            job_in.error     = mode_err;
            job_in.is_load   = (req_item.mode == MODE_LOAD);
            job_in.at_end    = at_end;
            job_in.pad_bytes = pad_prod[1:0];
            job_pix_in       = mem_wr_data;
            job_scale_in     = s_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_W'(1);
         width_ff     <= SRC_W'(1);
         col_ff       <= '0;
         pass_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         col_ff       <= col_in;
         pass_ff      <= pass_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      job_pix_ff   <= job_pix_in;
      job_scale_ff <= job_scale_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign job_pix   = job_pix_ff;
   assign job_scale = job_scale_ff;

endmodule

### design/pru_emitter.sv
// Copy emitter: sends each pixel out scale times on rsp_, one copy per cycle unless stalled.
module pru_emitter import pru_pkg::*; #(
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_take,
   input  job_type          job,
   input  logic [PIX_W-1:0] job_pix,
   input  logic [CNT_W-1:0] job_scale,
   input  logic [PIX_W-1:0] mem_rd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_item
);

   logic             valid_ff, valid_in;
   job_type          job_ff, job_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             final_copy, fire, done;

   assign final_copy = (rem_ff == '0);
   assign fire       = valid_ff && !rsp_stall;
   assign done       = fire && final_copy;
   assign job_take   = job_valid && (!valid_ff || done);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      pix_in   = pix_ff;
      rem_in   = rem_ff;
      if (fire && !final_copy) begin
         rem_in = rem_ff - CNT_W'(1);
      end
      if (!valid_ff || done) begin
         valid_in = job_valid;
         if (job_valid) begin
            job_in = job;
            pix_in = job.is_load ? job_pix : mem_rd_data;
            // An error item gives exactly one result.
            rem_in = job.error ? '0 : job_scale - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pix_ff <= pix_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      rsp_item = '0;
      if (job_ff.error) begin
         rsp_item.last  = 1'b1;
         rsp_item.error = 1'b1;
      end else begin
         rsp_item.out_blue  = pix_ff[7:0];
         rsp_item.out_green = pix_ff[15:8];
         rsp_item.out_red   = pix_ff[23:16];
         rsp_item.row_end   = job_ff.at_end && final_copy;
         rsp_item.pad_bytes = (job_ff.at_end && final_copy) ? job_ff.pad_bytes : 2'd0;
         rsp_item.last      = final_copy;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

### design/pixel_replicate_upscaler.sv
// Top level of the integer nearest-neighbor pixel upscaler.
//
// Items arrive on the req_ channel: a load item (mode 0) stores its pixel in the
// line buffer at the current column and is sent out scale times; after a full
// source row, (scale-1)*width replay items (mode 1) each read the next stored pixel
// and send it out scale times. Results leave on the rsp_ channel, one pixel copy per
// cycle unless stalled; the last copy of an output row carries row_end and the pad
// byte count. An item in the wrong mode gives a single error result and changes
// nothing. The csr_ port writes scale_factor (index 0) and source_width (index 1);
// each write restarts the row in the load pass.
// An accepted item waits in the job stage register until the emitter takes it, and
// its results come from the emitter's registers.
// Throughput: an item occupies the copy emitter until its scale copies are taken
// (a single result for an error item), so items sustain one per cycle at scale 1 while
// the receiver does not stall; the emitter's copy counter sets this rate. The line
// buffer is a single memory with one write and one registered read per cycle.
// Reset returns both registers to 1 and the row to the load pass; the line buffer is
// not cleared. When the receiver stalls, the current result holds, one further item
// waits in the job stage and req_stall rises until the emitter moves on.
module pixel_replicate_upscaler import pru_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_SCALE = DEF_MAX_SCALE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PASS_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int CNT_W  = $clog2(MAX_SCALE + 1);

   logic             mem_wr_en, mem_rd_en;
   logic [COL_W-1:0] mem_addr;
   logic [PIX_W-1:0] mem_wr_data, mem_rd_data;
   logic             job_valid, job_take;
   job_type          job;
   logic [PIX_W-1:0] job_pix;
   logic [CNT_W-1:0] job_scale;

   pru_control #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE),
      .COL_W     (COL_W),
      .PASS_W    (PASS_W),
      .CNT_W     (CNT_W)
   ) u_control (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .job_valid   (job_valid),
      .job_take    (job_take),
      .job         (job),
      .job_pix     (job_pix),
      .job_scale   (job_scale)
   );

   pru_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   pru_emitter #(
      .CNT_W (CNT_W)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_take    (job_take),
      .job         (job),
      .job_pix     (job_pix),
      .job_scale   (job_scale),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

### dv/pixel_replicate_upscaler_tb.sv
// Self-checking testbench for the pixel replicate upscaler: directed and random rows.
module pixel_replicate_upscaler_tb;
   import pru_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_item;

   // Idle rates in percent for the sender and the receiver.
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned error_count = 0;

   // Predictor state: registers, row position and the stored source row.
   logic [SCALE_W-1:0] scale_reg = 1;
   logic [SRC_W-1:0]   width_reg = 1;
   int unsigned        column_pos = 0;
   int unsigned        pass_num = 0;
   logic [PIX_W-1:0]   row_pixels [DEF_MAX_WIDTH];
   rsp_item_type       expected_copies [$];

   pixel_replicate_upscaler u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   function automatic int unsigned clamp_scale(input logic [SCALE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DEF_MAX_SCALE) return DEF_MAX_SCALE;
      return raw;
   endfunction

   function automatic int unsigned clamp_width(input logic [SRC_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return raw;
   endfunction

   // Works out the pixel copies (or the single error result) that one item causes.
   function automatic void predict_copies(input req_item_type it);
      int unsigned      s, w, col, pad;
      logic             phase_mode;
      logic [PIX_W-1:0] pix;
      rsp_item_type     r;
      s = clamp_scale(scale_reg);
      w = clamp_width(width_reg);
      col = (column_pos >= w) ? 0 : column_pos;
      phase_mode = (pass_num == 0) ? MODE_LOAD : MODE_REPLAY;
      if (it.mode != phase_mode) begin
         r = '0;
         r.last = 1'b1;
         r.error = 1'b1;
         expected_copies.push_back(r);
         return;
      end
      if (it.mode == MODE_LOAD) begin
         pix = {it.red, it.green, it.blue};
         row_pixels[col] = pix;
      end else begin
         pix = row_pixels[col];
      end
      pad = (4 - (w * s * 3) % 4) % 4;
      for (int k = 0; k < s; k++) begin
         r = '0;
         r.out_blue = pix[7:0];
         r.out_green = pix[15:8];
         r.out_red = pix[23:16];
         r.last = (k + 1 == s);
         r.row_end = r.last && (col + 1 == w);
         r.pad_bytes = r.row_end ? pad[1:0] : 2'd0;
         expected_copies.push_back(r);
      end
      col++;
      if (col >= w) begin
         col = 0;
         pass_num++;
         if (pass_num >= s) pass_num = 0;
      end
      column_pos = col;
   endfunction

   function automatic req_item_type random_item(input logic mode);
      req_item_type it;
      it.mode = mode;
      it.blue = 8'($urandom);
      it.green = 8'($urandom);
      it.red = 8'($urandom);
      return it;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_copies.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", rsp_item));
         end else begin
            want = expected_copies.pop_front();
            check_field("out_blue", rsp_item.out_blue, want.out_blue);
            check_field("out_green", rsp_item.out_green, want.out_green);
            check_field("out_red", rsp_item.out_red, want.out_red);
            check_field("pad_bytes", rsp_item.pad_bytes, want.pad_bytes);
            check_field("row_end", rsp_item.row_end, want.row_end);
            check_field("last", rsp_item.last, want.last);
            check_field("error", rsp_item.error, want.error);
         end
      end
   end

   // Sends one item, with random idle cycles ahead of it, and predicts its copies.
   task automatic send_item(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_copies(it);
   endtask

   // Stops sending and waits until every expected copy has come out.
   task automatic drain();
      int unsigned guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_copies.size() != 0 && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_SCALE_FACTOR) scale_reg = val[SCALE_W-1:0];
      else width_reg = val;
      // Any register write restarts the row in the load pass.
      column_pos = 0;
      pass_num = 0;
   endtask

   task automatic test_reset_defaults();
      req_item_type it;
      it = '{mode: MODE_LOAD, blue: 8'h00, green: 8'h00, red: 8'h00};
      send_item(it);
      it = '{mode: MODE_LOAD, blue: 8'hFF, green: 8'hFF, red: 8'hFF};
      send_item(it);
      it = '{mode: MODE_LOAD, blue: 8'hA5, green: 8'h5A, red: 8'h3C};
      send_item(it);
      // At scale 1 every item is a load, so a replay is always out of phase.
      send_item(random_item(MODE_REPLAY));
   endtask

   task automatic test_wrong_mode();
      write_csr(CSR_SCALE_FACTOR, 3);
      write_csr(CSR_SOURCE_WIDTH, 2);
      send_item(random_item(MODE_REPLAY));
      repeat (2) send_item(random_item(MODE_LOAD));
      send_item(random_item(MODE_LOAD));
      repeat (4) send_item(random_item(MODE_REPLAY));
      send_item(random_item(MODE_REPLAY));
   endtask

   task automatic test_scale_limits();
      // Scale above the maximum acts as the maximum; a later write cuts the row short.
      write_csr(CSR_SCALE_FACTOR, 31);
      write_csr(CSR_SOURCE_WIDTH, 1);
      send_item(random_item(MODE_LOAD));
      repeat (2) send_item(random_item(MODE_REPLAY));
      // Zero scale and zero width both act as one.
      write_csr(CSR_SCALE_FACTOR, 0);
      write_csr(CSR_SOURCE_WIDTH, 0);
      repeat (2) send_item(random_item(MODE_LOAD));
   endtask

   // A width above the maximum acts as the maximum, so a few loads stay inside one row.
   task automatic test_width_limit();
      write_csr(CSR_SCALE_FACTOR, 1);
      write_csr(CSR_SOURCE_WIDTH, 2047);
      repeat (8) send_item(random_item(MODE_LOAD));
   endtask

   // Random settings, each followed by whole frames with stray out-of-phase items
   // and sometimes a row that a register write cuts short.
   task automatic test_random_rows(input int unsigned budget);
      int unsigned        sent, s_eff, w_eff;
      logic [SCALE_W-1:0] s_raw;
      logic [SRC_W-1:0]   w_raw;
      sent = 0;
      while (sent < budget) begin
         s_raw = ($urandom_range(5) == 0) ? SCALE_W'($urandom_range(31))
                                          : SCALE_W'($urandom_range(1, 5));
         if (clamp_scale(s_raw) > 5) w_raw = SRC_W'($urandom_range(0, 2));
         else if ($urandom_range(5) == 0) w_raw = SRC_W'($urandom_range(0, 12));
         else w_raw = SRC_W'($urandom_range(1, 4));
         if ($urandom_range(1)) begin
            write_csr(CSR_SCALE_FACTOR, s_raw);
            write_csr(CSR_SOURCE_WIDTH, w_raw);
         end else begin
            write_csr(CSR_SOURCE_WIDTH, w_raw);
            write_csr(CSR_SCALE_FACTOR, s_raw);
         end
         s_eff = clamp_scale(s_raw);
         w_eff = clamp_width(w_raw);
         repeat ($urandom_range(1, 2)) begin
            for (int p = 0; p < s_eff; p++) begin
               for (int c = 0; c < w_eff; c++) begin
                  if ($urandom_range(11) == 0)
                     send_item(random_item(p == 0 ? MODE_REPLAY : MODE_LOAD));
                  send_item(random_item(p == 0 ? MODE_LOAD : MODE_REPLAY));
                  sent++;
               end
            end
         end
         if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, w_eff)) begin
               send_item(random_item(MODE_LOAD));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 20;
      receiver_stall_pct = 59;
      test_reset_defaults();
      test_wrong_mode();
      test_scale_limits();
      test_random_rows(50);

      sender_idle_pct = 59;
      receiver_stall_pct = 20;
      test_random_rows(50);

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      test_random_rows(50);
      test_width_limit();

      drain();
      if (expected_copies.size() != 0)
         report_mismatch($sformatf("%0d expected results never came", expected_copies.size()));
      if (error_count == 0) begin
         $display("pixel_replicate_upscaler_tb: done, clean");
      end else begin
         $display("pixel_replicate_upscaler_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("pixel_replicate_upscaler_tb: done, errors");
      $finish;
   end

endmodule

### sim.f
design/pru_pkg.sv
design/pru_line_store.sv
design/pru_control.sv
design/pru_emitter.sv
design/pixel_replicate_upscaler.sv
dv/pixel_replicate_upscaler_tb.sv
